// ===== src/gcd_pkg.sv =====
// Package for the greedy change dispenser: widths, shared types, FSM states.
// Used by every module in src.
`timescale 1ns / 1ps
package gcd_pkg;
  localparam int unsigned NumSlotsDef = 10;
  localparam int unsigned UnitW       = 16;
  localparam int unsigned AmtW        = 24;
  localparam int unsigned TotW        = 40;

  typedef struct packed {
    logic [UnitW-1:0] units;
    logic [UnitW-1:0] value;
  } slot_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SLOT, ST_DIV, ST_MUL, ST_UPD, ST_SUM, ST_EMIT
  } state_e;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_PAY  = 1'b1
  } action_e;
endpackage

// ===== src/gcd_slot_cell.sv =====
// One denomination slot of the drawer ring: holds units and value.
// Depends on gcd_pkg.
`timescale 1ns / 1ps
module gcd_slot_cell import gcd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  slot_t nbr_i,
  input  logic  wr_i,
  input  slot_t wr_data_i,
  output slot_t slot_o
);
  slot_t slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (wr_i) begin
      slot_q <= wr_data_i;
    end else if (shift_i) begin
      slot_q <= nbr_i;
    end
  end

  assign slot_o = slot_q;
endmodule

// ===== src/gcd_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on gcd_pkg.
`timescale 1ns / 1ps
module gcd_divider import gcd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AmtW-1:0]  dividend_i,
  input  logic [UnitW-1:0] divisor_i,
  output logic             busy_o,
  output logic [AmtW-1:0]  quo_o,
  output logic [UnitW-1:0] rem_o
);
  localparam int unsigned CntW = $clog2(AmtW);

  logic             busy_q;
  logic [CntW-1:0]  cnt_q;
  logic [AmtW-1:0]  quo_q;
  logic [UnitW-1:0] rem_q;
  logic [UnitW-1:0] dvs_q;
  logic [UnitW:0]   trial;
  logic             fits;

  assign trial = {rem_q, quo_q[AmtW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(AmtW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[AmtW-2:0], fits};
      rem_q <= fits ? UnitW'(trial - {1'b0, dvs_q}) : trial[UnitW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule

// ===== src/greedy_change_dispenser_core.sv =====
// Top level of the greedy change dispenser: slot ring, divider, sequencer.
// Depends on gcd_pkg, gcd_slot_cell, gcd_divider.
//
// channel | valid      | ready      | payload
// in      | in_valid_i | in_ready_o | action, slot_index, load_count/value, price, tendered
// out     | out_valid_o| out_ready_i| out_slot, delivered_count, success, change, total, ...
//
// One item at a time. A load ends with a drawer sum walk of the ring.
// A payment makes two passes over the ring, using the shared 24-step divider at
// most once per nonzero slot in each pass, then ends with the drawer sum walk.
// Reset empties all slots and sets the payment number to one.
// A stalled output holds the sequencer until the result is taken.
`timescale 1ns / 1ps
module greedy_change_dispenser_core import gcd_pkg::*; #(
  parameter int unsigned NUM_SLOTS = NumSlotsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  action_i,
  input  logic [3:0]            slot_index_i,
  input  logic [UnitW-1:0]      load_count_i,
  input  logic [UnitW-1:0]      load_value_i,
  input  logic [AmtW-1:0]       price_i,
  input  logic [AmtW-1:0]       tendered_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [3:0]            out_slot_o,
  output logic [UnitW-1:0]      delivered_count_o,
  output logic                  success_o,
  output logic signed [AmtW:0]  change_amount_o,
  output logic [TotW-1:0]       drawer_total_o,
  output logic [UnitW-1:0]      payment_number_o,
  output logic                  last_o
);
  localparam int unsigned CntW = $clog2(NUM_SLOTS + 1);
  localparam logic [CntW-1:0] LastCnt = CntW'(NUM_SLOTS - 1);
  localparam logic [CntW-1:0] EndCnt  = CntW'(NUM_SLOTS);

  state_e state_q, state_d;
  slot_t  ring [NUM_SLOTS];
  slot_t  head, tail_d, wr_data;
  logic   shift;

  logic             action_q, phase_q, phase_d, skip_q, skip_d;
  logic [3:0]       idx_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AmtW:0]    chg_q;
  logic [AmtW-1:0]  rest_q, rest_d;
  logic [UnitW-1:0] pay_q, lastk_q, lastk_d;
  logic [2*UnitW-1:0] prod_q;
  logic [TotW-1:0]  acc_q, acc_d;
  logic             chg_pos;

  logic             div_start, div_busy;
  logic [AmtW-1:0]  quo;
  logic [UnitW-1:0] rem;
  logic [AmtW:0]    usum;
  logic [UnitW-1:0] kpay;
  logic             capped;

  logic             ov_q, ov_d;
  logic [3:0]       os_q, os_d;
  logic [UnitW-1:0] od_q, od_d, opn_q, opn_d;
  logic             osu_q, osu_d, ol_q, ol_d;
  logic [AmtW:0]    oc_q, oc_d;
  logic [TotW-1:0]  ot_q, ot_d;
  logic             out_free, ok;

  assign head    = ring[0];
  assign wr_data = '{units: load_count_i, value: load_value_i};
  assign in_ready_o = (state_q == ST_IDLE);

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    slot_t nbr;
    if (i == NUM_SLOTS - 1) begin : g_tail
      assign nbr = tail_d;
    end else begin : g_mid
      assign nbr = ring[i+1];
    end
    gcd_slot_cell u_cell (
      .clk_i,
      .rst_ni,
      .shift_i  (shift),
      .nbr_i    (nbr),
      .wr_i     (in_valid_i && in_ready_o && action_i == ACT_LOAD
                 && slot_index_i == 4'(i)),
      .wr_data_i(wr_data),
      .slot_o   (ring[i])
    );
  end

  gcd_divider u_div (
    .clk_i,
    .rst_ni,
    .start_i   (div_start),
    .dividend_i(rest_q),
    .divisor_i (head.value),
    .busy_o    (div_busy),
    .quo_o     (quo),
    .rem_o     (rem)
  );

  assign chg_pos = !chg_q[AmtW] && (chg_q != '0);
  assign usum    = {{(AmtW-UnitW+1){1'b0}}, head.units} + {1'b0, quo};
  assign capped  = quo > {{(AmtW-UnitW){1'b0}}, head.units};
  assign kpay    = capped ? head.units : quo[UnitW-1:0];
  assign out_free = !ov_q || out_ready_i;
  assign ok      = !chg_q[AmtW] && (rest_q == '0);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    skip_d  = skip_q;
    cnt_d   = cnt_q;
    rest_d  = rest_q;
    lastk_d = lastk_q;
    acc_d   = acc_q;
    shift   = 1'b0;
    tail_d  = head;
    div_start = 1'b0;
    ov_d  = ov_q && !out_ready_i;
    os_d  = os_q;
    od_d  = od_q;
    osu_d = osu_q;
    oc_d  = oc_q;
    ot_d  = ot_q;
    opn_d = opn_q;
    ol_d  = ol_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cnt_d   = '0;
          phase_d = 1'b0;
          acc_d   = '0;
          rest_d  = tendered_i;
          lastk_d = '0;
          state_d = (action_i == ACT_LOAD) ? ST_SUM : ST_SLOT;
        end
      end
      ST_SLOT: begin
        if (cnt_q == EndCnt) begin
          cnt_d = '0;
          if (!phase_q) begin
            phase_d = 1'b1;
            rest_d  = chg_q[AmtW-1:0];
          end else begin
            acc_d   = '0;
            state_d = ST_SUM;
          end
        end else if (head.value == '0 || (phase_q && !chg_pos)) begin
          skip_d  = 1'b1;
          state_d = ST_UPD;
        end else begin
          skip_d    = 1'b0;
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_UPD;
      ST_UPD: begin
        if (!phase_q || cnt_q == LastCnt || out_free) begin
          shift   = 1'b1;
          cnt_d   = cnt_q + 1'b1;
          state_d = ST_SLOT;
          if (!skip_q) begin
            if (!phase_q) begin
              tail_d.units = usum[AmtW:UnitW] != '0 ? '1 : usum[UnitW-1:0];
              rest_d       = {{(AmtW-UnitW){1'b0}}, rem};
            end else begin
              tail_d.units = head.units - kpay;
              rest_d = capped ? rest_q - prod_q[AmtW-1:0]
                              : {{(AmtW-UnitW){1'b0}}, rem};
            end
          end
          if (phase_q) begin
            if (cnt_q == LastCnt) begin
              lastk_d = skip_q ? '0 : kpay;
            end else begin
              ov_d  = 1'b1;
              os_d  = 4'(cnt_q);
              od_d  = skip_q ? '0 : kpay;
              osu_d = 1'b0;
              oc_d  = '0;
              ot_d  = '0;
              opn_d = '0;
              ol_d  = 1'b0;
            end
          end
        end
      end
      ST_SUM: begin
        if (cnt_q != '0) begin
          acc_d = acc_q + TotW'(prod_q);
        end
        if (cnt_q == EndCnt) begin
          state_d = ST_EMIT;
        end else begin
          shift = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ov_d  = 1'b1;
          ot_d  = acc_q;
          opn_d = pay_q;
          ol_d  = 1'b1;
          if (action_q == ACT_LOAD) begin
            os_d  = idx_q;
            od_d  = '0;
            osu_d = 1'b1;
            oc_d  = '0;
          end else begin
            os_d  = 4'(LastCnt);
            od_d  = lastk_q;
            osu_d = ok;
            oc_d  = chg_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
      pay_q   <= UnitW'(1);
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      if (state_q == ST_EMIT && out_free && action_q == ACT_PAY && ok) begin
        pay_q <= pay_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      action_q <= action_i;
      idx_q    <= slot_index_i;
      chg_q    <= {1'b0, tendered_i} - {1'b0, price_i};
    end
    prod_q  <= head.units * head.value;
    skip_q  <= skip_d;
    rest_q  <= rest_d;
    lastk_q <= lastk_d;
    acc_q   <= acc_d;
    os_q    <= os_d;
    od_q    <= od_d;
    osu_q   <= osu_d;
    oc_q    <= oc_d;
    ot_q    <= ot_d;
    opn_q   <= opn_d;
    ol_q    <= ol_d;
  end

  assign out_valid_o       = ov_q;
  assign out_slot_o        = os_q;
  assign delivered_count_o = od_q;
  assign success_o         = osu_q;
  assign change_amount_o   = oc_q;
  assign drawer_total_o    = ot_q;
  assign payment_number_o  = opn_q;
  assign last_o            = ol_q;

  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !div_busy) else $error("divider busy while idle");
  a_cnt_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= EndCnt) else $error("slot counter out of range");
  a_pay_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(pay_q) |-> $past(state_q == ST_EMIT)) else $error("payment number moved");
endmodule

// ===== dv/greedy_change_dispenser_core_test.sv =====
// Self-checking testbench for greedy_change_dispenser_core: slot loads and payment
// transactions are predicted in the bench and compared result by result.
// Depends on gcd_pkg and the core RTL.
`timescale 1ns / 1ps
module greedy_change_dispenser_core_test;
  import gcd_pkg::*;

  localparam int unsigned NSLOT = NumSlotsDef;

  typedef struct packed {
    logic [3:0]       slot;
    logic [UnitW-1:0] delivered;
    logic             success;
    logic [AmtW:0]    change;
    logic [TotW-1:0]  total;
    logic [UnitW-1:0] pay_num;
    logic             last;
  } dispense_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic             action_i = 1'b0;
  logic [3:0]       slot_index_i = '0;
  logic [UnitW-1:0] load_count_i = '0;
  logic [UnitW-1:0] load_value_i = '0;
  logic [AmtW-1:0]  price_i = '0;
  logic [AmtW-1:0]  tendered_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [3:0]       out_slot_o;
  logic [UnitW-1:0] delivered_count_o;
  logic             success_o;
  logic signed [AmtW:0] change_amount_o;
  logic [TotW-1:0]  drawer_total_o;
  logic [UnitW-1:0] payment_number_o;
  logic             last_o;

  greedy_change_dispenser_core i_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [UnitW-1:0] units_q [NSLOT];
  logic [UnitW-1:0] denom_q [NSLOT];
  logic [UnitW-1:0] pay_count_q;
  dispense_t        pending_dispense[$];
  int               n_errors = 0;
  int               n_results = 0;
  int               n_items = 0;
  int               n_ok_pay = 0;
  bit               idle_en = 1'b1;
  bit               long_hold_req = 1'b0;
  int               hold_off_cycles = 0;

  function automatic logic [TotW-1:0] drawer_value();
    logic [63:0] acc;
    acc = 0;
    for (int s = 0; s < NSLOT; s++) acc += 64'(units_q[s]) * 64'(denom_q[s]);
    return acc[TotW-1:0];
  endfunction

  task automatic predict_dispense(action_e act, logic [3:0] idx, logic [UnitW-1:0] cnt,
                                  logic [UnitW-1:0] val, logic [AmtW-1:0] price,
                                  logic [AmtW-1:0] tend);
    dispense_t   r;
    logic [63:0] rest, k, u;
    longint      chg;
    logic [UnitW-1:0] got [NSLOT];
    bit          ok;
    r = '0;
    if (act == ACT_LOAD) begin
      if (idx < NSLOT) begin
        units_q[idx] = cnt;
        denom_q[idx] = val;
      end
      r.slot = idx; r.success = 1'b1; r.total = drawer_value();
      r.pay_num = pay_count_q; r.last = 1'b1;
      pending_dispense.push_back(r);
      return;
    end
    rest = tend;
    for (int s = 0; s < NSLOT; s++) begin
      if (denom_q[s] != 0) begin
        k = rest / denom_q[s];
        rest -= k * denom_q[s];
        u = 64'(units_q[s]) + k;
        units_q[s] = (u > 64'hFFFF) ? 16'hFFFF : u[15:0];
      end
    end
    chg = longint'(tend) - longint'(price);
    rest = (chg > 0) ? 64'(chg) : 0;
    for (int s = 0; s < NSLOT; s++) begin
      k = 0;
      if (denom_q[s] != 0 && chg > 0) begin
        k = rest / denom_q[s];
        if (k > units_q[s]) k = units_q[s];
        rest -= k * denom_q[s];
        units_q[s] = units_q[s] - k[15:0];
      end
      got[s] = k[15:0];
    end
    ok = (chg >= 0) && (rest == 0);
    for (int s = 0; s < NSLOT; s++) begin
      r = '0;
      r.slot = s[3:0];
      r.delivered = got[s];
      if (s == NSLOT - 1) begin
        r.success = ok; r.change = chg[AmtW:0]; r.total = drawer_value();
        r.pay_num = pay_count_q; r.last = 1'b1;
      end
      pending_dispense.push_back(r);
    end
    if (ok) begin
      pay_count_q = pay_count_q + 1'b1;
      n_ok_pay++;
    end
  endtask

  task automatic send_item(action_e act, logic [3:0] idx, logic [UnitW-1:0] cnt,
                           logic [UnitW-1:0] val, logic [AmtW-1:0] price,
                           logic [AmtW-1:0] tend);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    action_i <= act; slot_index_i <= idx; load_count_i <= cnt; load_value_i <= val;
    price_i <= price; tendered_i <= tend; in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_dispense(act, idx, cnt, val, price, tend);
    n_items++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_dispense.size() != 0) @(posedge clk_i);
    repeat (2 * NSLOT * (AmtW + 3) + NSLOT + 8) @(posedge clk_i);
  endtask

  // Output side: random stalls, optional long hold-off.
  always @(posedge clk_i) begin
    if (long_hold_req) begin
      long_hold_req   <= 1'b0;
      out_ready_i     <= 1'b0;
      hold_off_cycles <= 2999;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready_i <= 1'b0;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      out_ready_i <= 1'b0;
      hold_off_cycles <= $urandom_range(0, 12);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    dispense_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (pending_dispense.size() == 0) begin
        $error("unexpected result slot=%0d", out_slot_o);
        n_errors++;
      end else begin
        want = pending_dispense.pop_front();
        if (out_slot_o !== want.slot) begin
          $error("out_slot exp %0d got %0d", want.slot, out_slot_o); n_errors++;
        end
        if (delivered_count_o !== want.delivered) begin
          $error("delivered_count exp %0d got %0d", want.delivered, delivered_count_o);
          n_errors++;
        end
        if (success_o !== want.success) begin
          $error("success exp %0d got %0d", want.success, success_o); n_errors++;
        end
        if (change_amount_o !== want.change) begin
          $error("change_amount exp %h got %h", want.change, change_amount_o); n_errors++;
        end
        if (drawer_total_o !== want.total) begin
          $error("drawer_total exp %0d got %0d", want.total, drawer_total_o); n_errors++;
        end
        if (payment_number_o !== want.pay_num) begin
          $error("payment_number exp %0d got %0d", want.pay_num, payment_number_o);
          n_errors++;
        end
        if (last_o !== want.last) begin
          $error("last exp %0d got %0d", want.last, last_o); n_errors++;
        end
      end
    end
  end

  task automatic load_cash_set();
    logic [UnitW-1:0] set_val [NSLOT] = '{5000, 2000, 1000, 500, 200, 100, 50, 20, 10, 1};
    for (int s = 0; s < NSLOT; s++)
      send_item(ACT_LOAD, s[3:0], 16'($urandom_range(0, 40)), set_val[s], '0, '0);
  endtask

  task automatic test_directed();
    load_cash_set();
    send_item(ACT_PAY, '0, '0, '0, 24'd1234, 24'd5000);
    send_item(ACT_PAY, '0, '0, '0, 24'd5000, 24'd1234);
    send_item(ACT_PAY, '0, '0, '0, 24'd777, 24'd777);
    send_item(ACT_PAY, '0, '0, '0, '0, 24'hFFFFFF);
    send_item(ACT_PAY, '0, '0, '0, 24'hFFFFFF, '0);
    send_item(ACT_LOAD, 4'd15, 16'hFFFF, 16'hFFFF, '1, '1);
    send_item(ACT_LOAD, 4'd10, 16'h1234, 16'h4321, '0, '0);
    send_item(ACT_LOAD, 4'd3, '0, '0, '0, '0);
    send_item(ACT_LOAD, 4'd0, 16'hFFFF, 16'hFFFF, '0, '0);
    send_item(ACT_PAY, '0, '0, '0, 24'd3, 24'hFFFFFF);
    send_item(ACT_PAY, '0, '0, '0, '0, '0);
    send_item(ACT_LOAD, 4'd9, 16'd0, 16'd1, '0, '0);
    send_item(ACT_PAY, '0, '0, '0, 24'd1, 24'd3);
    drain();
  endtask

  task automatic test_random_pay(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: send_item(ACT_LOAD, 4'($urandom_range(0, 15)), 16'($urandom()), 16'($urandom()),
                     24'($urandom()), 24'($urandom()));
        1: send_item(ACT_LOAD, 4'($urandom_range(0, 9)), 16'($urandom_range(0, 100)),
                     16'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 2000)), '0, '0);
        2: send_item(ACT_PAY, 4'($urandom()), 16'($urandom()), 16'($urandom()),
                     24'($urandom()), 24'($urandom()));
        default: begin
          logic [AmtW-1:0] p;
          p = 24'($urandom_range(0, 20000));
          send_item(ACT_PAY, '0, '0, '0, p, p + 24'($urandom_range(0, 20000)));
        end
      endcase
    end
  endtask

  task automatic test_output_backpressure();
    long_hold_req = 1'b1;
    for (int i = 0; i < 4; i++) send_item(ACT_PAY, '0, '0, '0, 24'd100, 24'd9999);
    drain();
  endtask

  initial begin
    pay_count_q = 1;
    for (int s = 0; s < NSLOT; s++) begin
      units_q[s] = '0;
      denom_q[s] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_pay(80);
    test_output_backpressure();
    load_cash_set();
    test_random_pay(80);
    drain();
    idle_en = 1'b0;
    test_random_pay(40);
    drain();
    $display("Sent %0d items, checked %0d results, %0d successful payments.",
             n_items, n_results, n_ok_pay);
    if (n_errors == 0 && pending_dispense.size() == 0) begin
      $display("greedy_change_dispenser_core verification clean");
    end else begin
      $display("greedy_change_dispenser_core verification failed");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("greedy_change_dispenser_core verification failed");
    $finish;
  end
endmodule
